[src/mmfn_pkg.sv]
package mmfn_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SLOT_W     = 11;
  localparam int unsigned COUNT_IN_W = 24;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned TOTAL_W    = 16;

  // Width of the divider step counter, able to hold NORM_W itself.
  localparam int unsigned STEP_W = $clog2(NORM_W + 1);

  localparam logic [TOTAL_W-1:0] COUNTER_MAX = {TOTAL_W{1'b1}};
  localparam logic [NORM_W-1:0]  NORM_MAX    = {NORM_W{1'b1}};

  // Request kinds carried on the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  // Control part of a job handed from the front end to the back end.
  typedef struct packed {
    logic               need_div;
    logic               degenerate;
    logic [TOTAL_W-1:0] update_total;
  } job_ctrl_t;

endpackage

[src/mmfn_fifo.sv]
module mmfn_fifo #(
  parameter int unsigned WIDTH = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  // Two-entry queue between the front end and the back end.
  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/mmfn_front.sv]
module mmfn_front #(
  parameter int unsigned SLOTS      = 2048,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [mmfn_pkg::KIND_W-1:0]    req_kind_i,
  input  logic [mmfn_pkg::SLOT_W-1:0]    req_slot_i,
  input  logic [mmfn_pkg::COUNT_IN_W-1:0] req_count_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output mmfn_pkg::job_ctrl_t            job_ctrl_o,
  output logic [COUNT_BITS-1:0]          job_num_o,
  output logic [COUNT_BITS-1:0]          job_range_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_PUSH  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                min_q, min_d;
  logic [CW-1:0]                max_q, max_d;
  logic                         any_q, any_d;
  logic [mmfn_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [AW-1:0]                clr_cnt_q, clr_cnt_d;
  logic                         clr_job_q, clr_job_d;
  logic                         rd_ok_q, rd_ok_d;
  mmfn_pkg::job_ctrl_t          job_ctrl_q, job_ctrl_d;
  logic [CW-1:0]                job_num_q, job_num_d;
  logic [CW-1:0]                job_range_q, job_range_d;

  // Slot memory: valid bit on top of the stored count.
  logic [CW:0]   mem_q [SLOTS];
  logic [CW:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW:0]   mem_wdata;

  logic          accept;
  logic [31:0]   slot_ext;
  logic [AW-1:0] slot_idx;
  logic          in_range;
  logic [55:0]   count_ext;
  logic [CW-1:0] count_val;
  logic [CW-1:0] upd_min, upd_max;
  logic [CW-1:0] rd_x;
  logic          rd_deg;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign slot_ext    = 32'(req_slot_i);
  assign slot_idx    = slot_ext[AW-1:0];
  assign in_range    = (slot_ext < SLOTS);
  assign count_ext   = 56'(req_count_i);
  assign count_val   = count_ext[CW-1:0];
  assign upd_min     = (count_val < min_q) ? count_val : min_q;
  assign upd_max     = (count_val > max_q) ? count_val : max_q;
  assign rd_x        = rdata_q[CW-1:0];
  assign rd_deg      = !any_q || (max_q == min_q);

  assign job_valid_o = (state_q == S_PUSH);
  assign job_ctrl_o  = job_ctrl_q;
  assign job_num_o   = job_num_q;
  assign job_range_o = job_range_q;

  // Request classification, running statistics and job building.
  always_comb begin
    state_d     = state_q;
    min_d       = min_q;
    max_d       = max_q;
    any_d       = any_q;
    total_d     = total_q;
    clr_cnt_d   = clr_cnt_q;
    clr_job_d   = clr_job_q;
    rd_ok_d     = rd_ok_q;
    job_ctrl_d  = job_ctrl_q;
    job_num_d   = job_num_q;
    job_range_d = job_range_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_idx;
    mem_wdata   = {1'b1, count_val};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          job_num_d   = '0;
          job_range_d = '0;
          case (mmfn_pkg::kind_e'(req_kind_i))
            mmfn_pkg::KIND_CLEAR: begin
              min_d      = '1;
              max_d      = '0;
              any_d      = 1'b0;
              total_d    = '0;
              job_ctrl_d = '{need_div: 1'b0, degenerate: 1'b1, update_total: '0};
              clr_cnt_d  = '0;
              clr_job_d  = 1'b1;
              state_d    = S_CLEAR;
            end
            mmfn_pkg::KIND_UPDATE: begin
              if (in_range) begin
                mem_we  = 1'b1;
                min_d   = upd_min;
                max_d   = upd_max;
                any_d   = 1'b1;
                total_d = (total_q != mmfn_pkg::COUNTER_MAX) ? total_q + 1'b1 : total_q;
              end
              job_ctrl_d.need_div     = 1'b0;
              job_ctrl_d.degenerate   = !any_d || (max_d == min_d);
              job_ctrl_d.update_total = total_d;
              state_d                 = S_PUSH;
            end
            default: begin
              rd_ok_d = (mmfn_pkg::kind_e'(req_kind_i) == mmfn_pkg::KIND_READ) && in_range;
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        job_ctrl_d.need_div     = rd_ok_q && rdata_q[CW] && !rd_deg &&
                                  (rd_x != '0) && (rd_x > min_q);
        job_ctrl_d.degenerate   = rd_deg;
        job_ctrl_d.update_total = total_q;
        job_num_d               = rd_x - min_q;
        job_range_d             = max_q - min_q;
        state_d                 = S_PUSH;
      end
      S_PUSH: begin
        if (job_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == AW'(SLOTS - 1)) begin
          state_d   = clr_job_q ? S_PUSH : S_IDLE;
          clr_job_d = 1'b0;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      min_q     <= '1;
      max_q     <= '0;
      any_q     <= 1'b0;
      total_q   <= '0;
      clr_cnt_q <= '0;
      clr_job_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      min_q     <= min_d;
      max_q     <= max_d;
      any_q     <= any_d;
      total_q   <= total_d;
      clr_cnt_q <= clr_cnt_d;
      clr_job_q <= clr_job_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // Job payload registers.
  always_ff @(posedge clk_i) begin
    job_ctrl_q  <= job_ctrl_d;
    job_num_q   <= job_num_d;
    job_range_q <= job_range_d;
  end

  // Slot memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata_q <= mem_q[slot_idx];
    end
  end

  // With no update since the last clear, the statistics sit at their clear values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (min_q == '1) && (max_q == '0) && (total_q == '0))
    else $error("statistics not at clear values without updates");

  // Once updated, the running minimum never exceeds the running maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  // A division job always has a nonzero range and a numerator within it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_ctrl_q.need_div |-> (job_range_q != '0) && (job_num_q <= job_range_q))
    else $error("division job out of range");

endmodule

[src/mmfn_back.sv]
module mmfn_back #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  mmfn_pkg::job_ctrl_t           job_ctrl_i,
  input  logic [COUNT_BITS-1:0]         job_num_i,
  input  logic [COUNT_BITS-1:0]         job_range_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [mmfn_pkg::NORM_W-1:0]   res_norm_o,
  output logic                          res_degenerate_o,
  output logic [mmfn_pkg::TOTAL_W-1:0]  res_total_o
);

  localparam int unsigned CW = COUNT_BITS;
  localparam logic [mmfn_pkg::STEP_W-1:0] LAST_STEP = mmfn_pkg::STEP_W'(mmfn_pkg::NORM_W);

  logic                          busy_q, busy_d;
  logic [mmfn_pkg::STEP_W-1:0]   step_q, step_d;
  logic [CW-1:0]                 rem_q, rem_d;
  logic [CW-1:0]                 div_q, div_d;
  logic [mmfn_pkg::NORM_W-1:0]   quo_q, quo_d;
  logic                          deg_q, deg_d;
  logic [mmfn_pkg::TOTAL_W-1:0]  tot_q, tot_d;
  logic                          out_valid_q, out_valid_d;
  logic [mmfn_pkg::NORM_W-1:0]   out_norm_q, out_norm_d;
  logic                          out_deg_q, out_deg_d;
  logic [mmfn_pkg::TOTAL_W-1:0]  out_tot_q, out_tot_d;

  logic          out_free;
  logic          pop;
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_sub;
  logic          rem_ge;

  assign out_free    = !out_valid_q || res_ready_i;
  assign job_ready_o = !busy_q && (job_ctrl_i.need_div || out_free);
  assign pop         = job_valid_i && job_ready_o;

  // One restoring division step per cycle.
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, div_q});
  assign rem_sub   = rem_shift - {1'b0, div_q};

  assign res_valid_o      = out_valid_q;
  assign res_norm_o       = out_norm_q;
  assign res_degenerate_o = out_deg_q;
  assign res_total_o      = out_tot_q;

  // Job intake, division sequencing and output register loading.
  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quo_d       = quo_q;
    deg_d       = deg_q;
    tot_d       = tot_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_norm_d  = out_norm_q;
    out_deg_d   = out_deg_q;
    out_tot_d   = out_tot_q;

    if (pop) begin
      if (job_ctrl_i.need_div) begin
        busy_d = 1'b1;
        div_d  = job_range_i;
        deg_d  = job_ctrl_i.degenerate;
        tot_d  = job_ctrl_i.update_total;
        rem_d  = job_num_i;
        // A numerator equal to the range gives one, which saturates.
        if (job_num_i >= job_range_i) begin
          quo_d  = mmfn_pkg::NORM_MAX;
          step_d = LAST_STEP;
        end else begin
          quo_d  = '0;
          step_d = '0;
        end
      end else begin
        out_valid_d = 1'b1;
        out_norm_d  = '0;
        out_deg_d   = job_ctrl_i.degenerate;
        out_tot_d   = job_ctrl_i.update_total;
      end
    end else if (busy_q) begin
      if (step_q != LAST_STEP) begin
        rem_d  = rem_ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
        quo_d  = {quo_q[mmfn_pkg::NORM_W-2:0], rem_ge};
        step_d = step_q + 1'b1;
      end else if (out_free) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        out_norm_d  = quo_q;
        out_deg_d   = deg_q;
        out_tot_d   = tot_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    quo_q      <= quo_d;
    deg_q      <= deg_d;
    tot_q      <= tot_d;
    out_norm_q <= out_norm_d;
    out_deg_q  <= out_deg_d;
    out_tot_q  <= out_tot_d;
  end

  // A running division is not abandoned before its last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (step_q != LAST_STEP) |=> busy_q)
    else $error("division dropped before completion");

  // A degenerate result never carries a nonzero normalized value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_deg_q |-> (out_norm_q == '0))
    else $error("degenerate result with nonzero value");

  // The divisor of a running division is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (div_q != '0))
    else $error("division by zero range");

endmodule

[src/minmax_feature_normalizer_top.sv]
// Throughput: one request at a time in the front end; divided reads are bound by the
// one-bit-per-cycle divider, which takes no new job while a division is running.
// Reset: asynchronous, active low; afterwards a clearing pass sweeps the slot
// memory, and no request is accepted until it ends.
module minmax_feature_normalizer_top #(
  parameter int unsigned SLOTS      = 2048,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot [10:0], count_in [34:11], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // norm_value [15:0], update_total [31:16]
  output logic [0:0]  m_axis_tuser   // degenerate [0]
);

  localparam int unsigned JOB_W = $bits(mmfn_pkg::job_ctrl_t) + 2 * COUNT_BITS;

  logic                          fr_job_valid, fr_job_ready;
  mmfn_pkg::job_ctrl_t           fr_job_ctrl;
  logic [COUNT_BITS-1:0]         fr_job_num, fr_job_range;
  logic                          bk_job_valid, bk_job_ready;
  logic [JOB_W-1:0]              bk_job_data;
  mmfn_pkg::job_ctrl_t           bk_job_ctrl;
  logic [COUNT_BITS-1:0]         bk_job_num, bk_job_range;
  logic [mmfn_pkg::NORM_W-1:0]   res_norm;
  logic                          res_deg;
  logic [mmfn_pkg::TOTAL_W-1:0]  res_total;

  // Front end: request intake, slot memory and running statistics.
  mmfn_front #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_kind_i  (s_axis_tuser),
    .req_slot_i  (s_axis_tdata[10:0]),
    .req_count_i (s_axis_tdata[34:11]),
    .job_valid_o (fr_job_valid),
    .job_ready_i (fr_job_ready),
    .job_ctrl_o  (fr_job_ctrl),
    .job_num_o   (fr_job_num),
    .job_range_o (fr_job_range)
  );

  // Job queue between the two halves.
  mmfn_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_job_valid),
    .push_ready_o (fr_job_ready),
    .push_data_i  ({fr_job_ctrl, fr_job_num, fr_job_range}),
    .pop_valid_o  (bk_job_valid),
    .pop_ready_i  (bk_job_ready),
    .pop_data_o   (bk_job_data)
  );

  assign {bk_job_ctrl, bk_job_num, bk_job_range} = bk_job_data;

  // Back end: divider and output register.
  mmfn_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (bk_job_valid),
    .job_ready_o      (bk_job_ready),
    .job_ctrl_i       (bk_job_ctrl),
    .job_num_i        (bk_job_num),
    .job_range_i      (bk_job_range),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_norm_o       (res_norm),
    .res_degenerate_o (res_deg),
    .res_total_o      (res_total)
  );

  assign m_axis_tdata = {res_total, res_norm};
  assign m_axis_tuser = res_deg;

endmodule
